[hw/rtl/fbfa_pkg.sv]
// Shared constants and codes for the first-fit / best-fit block allocator.
package fbfa_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 8;

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int HEAP_W = $clog2(HEAP_BYTES + 1);
  localparam int ADDR_W = 16;
  localparam int SIZE_W = 17;
  localparam int WIDE_W = 26;
  localparam int ADDR_MAX = 65535;

  // table word: {start, size, free}
  localparam int WORD_W = ADDR_W + SIZE_W + 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_t;

endpackage

[hw/rtl/first_or_best_fit_block_allocator_top.sv]
// Heap block allocator: block table in one memory, scanned one entry a cycle.
//
// Command channel: an item is taken at a rising edge with start high and busy
// low. op selects allocate (req_bytes used) or free (free_addr used).
// Result channel: done pulses for exactly one cycle with user_addr, status and
// grew_heap valid in that cycle. The receiver cannot stall; every item gives
// exactly one result.
// Config: cfg_we writes cfg_wdata into fit_mode (0 first fit, 1 best fit).
// Write it only while busy is low and no result is pending.
// Timing: the table (start, size, free) sits in a synchronous memory with one
// read and one write port, read one entry a cycle. First fit and free stop the
// scan at the first hit. busy drops in the done cycle, so a new item can be
// taken there, but not before the last item's result.
// Reset: rst (sync, active high) clears entry_count, heap_used, fit_mode and
// the sequencer. Words read at or above entry_count are never used, so the memory
// needs no clearing pass.
// Hazards: the only table write is in the decide cycle; the next item's first
// read comes only after an idle cycle has accepted it, so no forwarding is needed.
module first_or_best_fit_block_allocator_top
  import fbfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              op,
  input  logic [15:0]       req_bytes,
  input  logic [15:0]       free_addr,
  output logic              done,
  output logic [15:0]       user_addr,
  output logic [1:0]        status,
  output logic              grew_heap,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE} state_t;

  state_t state;

  // block table memory
  logic [WORD_W-1:0] mem [MAX_BLOCKS];
  logic [WORD_W-1:0] rd_word;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  // control and bookkeeping
  logic              fit_mode;
  logic [CNT_W-1:0]  entry_count;
  logic [HEAP_W-1:0] heap_used;

  // latched item
  logic              cur_op;
  logic [SIZE_W-1:0] need;
  logic [ADDR_W-1:0] cur_addr;

  // scan pointers and match tracking
  logic [CNT_W-1:0]  issue_idx;
  logic [IDX_W-1:0]  chk_idx;
  logic              chk_valid;
  logic              found;
  logic [IDX_W-1:0]  pick_idx;
  logic [ADDR_W-1:0] pick_start;
  logic [SIZE_W-1:0] pick_size;
  logic [SIZE_W-1:0] best_surplus;

  // fields of the word read last cycle
  logic [ADDR_W-1:0] w_start;
  logic [SIZE_W-1:0] w_size;
  logic              w_free;
  logic [SIZE_W-1:0] surplus;
  logic              fits;
  logic              addr_hit;
  logic              scan_end;

  // append checks
  logic [WIDE_W-1:0] room;
  logic              no_space;

  assign busy = (state != S_IDLE);

  assign {w_start, w_size, w_free} = rd_word;
  assign surplus  = w_size - need;
  assign fits     = w_free && (w_size >= need);
  assign addr_hit = (({1'b0, w_start} + SIZE_W'(HEADER_BYTES)) == {1'b0, cur_addr});
  assign scan_end = !chk_valid && (issue_idx >= entry_count);

  assign room     = WIDE_W'(HEAP_BYTES) - WIDE_W'(heap_used);
  assign no_space = (entry_count >= CNT_W'(MAX_BLOCKS)) ||
                    (WIDE_W'(heap_used) > WIDE_W'(HEAP_BYTES)) ||
                    (WIDE_W'(need) > room) ||
                    ((WIDE_W'(heap_used) + WIDE_W'(HEADER_BYTES)) > WIDE_W'(ADDR_MAX));

  // table write-back in the decide cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pick_idx;
    mem_wdata = {pick_start, pick_size, 1'b0};
    if (state == S_DECIDE) begin
      if (cur_op == OP_FREE) begin
        mem_we    = found;
        mem_wdata = {pick_start, pick_size, 1'b1};
      end else if (found) begin
        mem_we    = 1'b1;
      end else begin
        mem_we    = !no_space;
        mem_waddr = entry_count[IDX_W-1:0];
        mem_wdata = {ADDR_W'(heap_used), need, 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_word <= mem[issue_idx[IDX_W-1:0]];
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= FIT_FIRST;
    end else if (cfg_we) begin
      fit_mode <= cfg_wdata;
    end
  end

  // sequencer: state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      entry_count <= '0;
      heap_used   <= '0;
      chk_valid   <= 1'b0;
      found       <= 1'b0;
      issue_idx   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state     <= S_SCAN;
            cur_op    <= op;
            need      <= {1'b0, req_bytes} + SIZE_W'(HEADER_BYTES);
            cur_addr  <= free_addr;
            issue_idx <= '0;
            chk_valid <= 1'b0;
            found     <= 1'b0;
          end
        end
        S_SCAN: begin
          if (issue_idx < entry_count) begin
            issue_idx <= issue_idx + CNT_W'(1);
            chk_valid <= 1'b1;
            chk_idx   <= issue_idx[IDX_W-1:0];
          end else begin
            chk_valid <= 1'b0;
          end
          if (chk_valid) begin
            if (cur_op == OP_FREE) begin
              if (addr_hit) begin
                found      <= 1'b1;
                pick_idx   <= chk_idx;
                pick_start <= w_start;
                pick_size  <= w_size;
                state      <= S_DECIDE;
              end
            end else if (fits && (!found || (fit_mode == FIT_BEST && surplus < best_surplus)))
            begin
              found        <= 1'b1;
              pick_idx     <= chk_idx;
              pick_start   <= w_start;
              pick_size    <= w_size;
              best_surplus <= surplus;
              if (fit_mode == FIT_FIRST) begin
                state <= S_DECIDE;
              end
            end
          end else if (scan_end) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state     <= S_IDLE;
          done      <= 1'b1;
          user_addr <= '0;
          grew_heap <= 1'b0;
          status    <= ST_OK;
          if (cur_op == OP_FREE) begin
            if (!found) begin
              status <= ST_BAD_ADDR;
            end
          end else if (found) begin
            user_addr <= pick_start + ADDR_W'(HEADER_BYTES);
          end else if (no_space) begin
            status <= ST_NO_SPACE;
          end else begin
            user_addr   <= ADDR_W'(WIDE_W'(heap_used) + WIDE_W'(HEADER_BYTES));
            grew_heap   <= 1'b1;
            entry_count <= entry_count + CNT_W'(1);
            heap_used   <= HEAP_W'(WIDE_W'(heap_used) + WIDE_W'(need));
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_done_from_decide: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DECIDE))
    else $error("result strobe without a decide cycle");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (user_addr == '0 && !grew_heap))
    else $error("error result carries an address or growth flag");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_BLOCKS))
    else $error("block table count overflow");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not start a scan");

endmodule

[sim/first_or_best_fit_block_allocator_top_test.sv]
// Self-checking testbench for the first-fit / best-fit heap block allocator.
`timescale 1ns / 100ps

module first_or_best_fit_block_allocator_top_test;
  import fbfa_pkg::*;

  // Longest legal quiet stretch: settle pause plus a sender gap plus a
  // full-table scan. QUIET_LIMIT leaves a wide margin.
  localparam int QUIET_LIMIT   = 1000;
  // Pause before any config write, longer than a full-table scan.
  localparam int SETTLE_CYCLES = 80;

  // One command item as queued for the driver.
  typedef struct {
    logic        op;
    logic [15:0] req;
    logic [15:0] addr;
    bit          hold_off;   // present only once every reply has come back
  } cmd_t;

  // One reply item, field for field as on the result ports.
  typedef struct packed {
    logic [15:0] user_addr;
    status_t     status;
    logic        grew;
  } reply_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic        op        = OP_ALLOC;
  logic [15:0] req_bytes = '0;
  logic [15:0] free_addr = '0;
  logic        cfg_we    = 1'b0;
  logic        cfg_wdata = FIT_FIRST;
  logic        busy;
  logic        done;
  logic [15:0] user_addr;
  logic [1:0]  status;
  logic        grew_heap;

  first_or_best_fit_block_allocator_top uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .req_bytes (req_bytes),
    .free_addr (free_addr),
    .done      (done),
    .user_addr (user_addr),
    .status    (status),
    .grew_heap (grew_heap),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the block table and heap end, updated as each item is accepted.
  logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
  logic [SIZE_W-1:0] blk_size  [MAX_BLOCKS];
  logic              blk_free  [MAX_BLOCKS];
  logic [CNT_W-1:0]  blk_cnt  = '0;
  logic [HEAP_W-1:0] heap_top = '0;
  logic              fit_best = FIT_FIRST;

  cmd_t   cmd_q[$];        // items waiting for the driver
  reply_t reply_q[$];      // replies owed by the block, oldest first
  cmd_t   drv_cmd;
  int     idle_pct   = 0;  // chance in 100 that the sender skips a cycle
  int     mismatches = 0;
  int     quiet      = 0;
  logic   settled    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predicts the reply to one item and applies its effect on the table.
  function automatic reply_t apply_heap_op(input logic op_i, input logic [15:0] req_i,
                                           input logic [15:0] addr_i);
    reply_t r;
    int     need;
    int     pick;
    int     best;
    bit     hit;
    r    = '{user_addr: '0, status: ST_OK, grew: 1'b0};
    hit  = 1'b0;
    pick = 0;
    best = 0;
    if (op_i == OP_FREE) begin
      // first entry whose user address matches; freeing a free block is fine
      for (int i = 0; i < int'(blk_cnt) && !hit; i++)
        if (int'(blk_start[i]) + HEADER_BYTES == int'(addr_i)) begin
          blk_free[i] = 1'b1;
          hit = 1'b1;
        end
      if (!hit)
        r.status = ST_BAD_ADDR;
    end else begin
      need = int'(req_i) + HEADER_BYTES;
      // first fit stops at the first candidate; best fit keeps the smallest
      // surplus, lowest address on a tie
      for (int i = 0; i < int'(blk_cnt) && !(hit && fit_best == FIT_FIRST); i++)
        if (blk_free[i] && int'(blk_size[i]) >= need)
          if (!hit || int'(blk_size[i]) - need < best) begin
            hit  = 1'b1;
            pick = i;
            best = int'(blk_size[i]) - need;
          end
      if (hit) begin
        blk_free[pick] = 1'b0;
        r.user_addr    = 16'(int'(blk_start[pick]) + HEADER_BYTES);
      end else if (int'(blk_cnt) >= MAX_BLOCKS || int'(heap_top) > HEAP_BYTES ||
                   need > HEAP_BYTES - int'(heap_top) ||
                   int'(heap_top) + HEADER_BYTES > ADDR_MAX) begin
        // table full, heap full, or user address past 16 bits
        r.status = ST_NO_SPACE;
      end else begin
        blk_start[blk_cnt] = ADDR_W'(heap_top);
        blk_size[blk_cnt]  = SIZE_W'(need);
        blk_free[blk_cnt]  = 1'b0;
        blk_cnt            = blk_cnt + 1'b1;
        r.user_addr        = 16'(int'(heap_top) + HEADER_BYTES);
        r.grew             = 1'b1;
        heap_top           = HEAP_W'(int'(heap_top) + need);
      end
    end
    return r;
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d at %0t: %s", mismatches, $time, msg);
  endfunction

  // Driver: holds an item until the block takes it, then offers the next one
  // or idles at random. A hold-off item waits for the reply queue to drain.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct &&
          (!cmd_q[0].hold_off || (!start && settled))) begin
        drv_cmd = cmd_q.pop_front();
        start     <= 1'b1;
        op        <= drv_cmd.op;
        req_bytes <= drv_cmd.req;
        free_addr <= drv_cmd.addr;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each reply against the oldest prediction, then predicts
  // for an item accepted at this edge. Replies cannot be stalled.
  always @(posedge clk) begin : watch_replies
    reply_t got;
    reply_t want;
    if (rst) begin
      blk_cnt  = '0;
      heap_top = '0;
      fit_best = FIT_FIRST;
      reply_q.delete();
    end else begin
      if (done) begin
        got = '{user_addr: user_addr, status: status_t'(status), grew: grew_heap};
        if (reply_q.size() == 0) begin
          flag_error($sformatf("unexpected reply: user_addr %0d status %0d grew_heap %0b",
                               user_addr, status, grew_heap));
        end else begin
          want = reply_q.pop_front();
          if (got.user_addr !== want.user_addr)
            flag_error($sformatf("user_addr expected %0d got %0d",
                                 want.user_addr, got.user_addr));
          if (got.status !== want.status)
            flag_error($sformatf("status expected %0d got %0d", want.status, status));
          if (got.grew !== want.grew)
            flag_error($sformatf("grew_heap expected %0b got %0b", want.grew, got.grew));
        end
      end
      if (start && !busy)
        reply_q.push_back(apply_heap_op(op, req_bytes, free_addr));
      if (cfg_we)
        fit_best = cfg_wdata;
    end
  end

  // Sampled away from the active edge so the driver reads it race-free.
  always @(negedge clk)
    settled <= (reply_q.size() == 0);

  // Watchdog: any handshake restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_cmd(input logic o, input int r, input int a, input bit h);
    cmd_t c;
    c.op       = o;
    c.req      = 16'(r);
    c.addr     = 16'(a);
    c.hold_off = h;
    cmd_q.push_back(c);
  endtask

  task automatic write_fit(input logic m);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= ~m;
  endtask

  // Wait until nothing is queued, offered or owed, then let the block go idle.
  task automatic settle();
    do @(negedge clk); while (cmd_q.size() != 0 || start || reply_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed traffic: small allocations (many of equal size, so
  // best fit sees ties), frees of blocks in the table, some oversized requests and
  // some frees of unknown or near-miss addresses. Ignored fields are random.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    int   lo;
    pick       = $urandom_range(99);
    c.op       = OP_ALLOC;
    c.req      = 16'($urandom());
    c.addr     = 16'($urandom());
    c.hold_off = ($urandom_range(63) == 0);
    lo = 65529 - int'(heap_top);
    if (lo < 0)
      lo = 0;
    if (pick < 46) begin
      c.req = $urandom_range(1) ? 16'($urandom_range(15) * 8) : 16'($urandom_range(700));
    end else if (pick < 52) begin
      c.req = 16'($urandom_range(65535, lo));   // too big for what is left
    end else if (pick < 90 && blk_cnt != 0) begin
      c.op   = OP_FREE;
      c.addr = blk_start[$urandom_range(int'(blk_cnt) - 1)] + 16'(HEADER_BYTES);
    end else if (pick < 95 && blk_cnt != 0) begin
      c.op   = OP_FREE;
      c.addr = 16'(int'(blk_start[$urandom_range(int'(blk_cnt) - 1)]) + HEADER_BYTES +
                   int'($urandom_range(15)) - 8);
    end else begin
      c.op = OP_FREE;
    end
    return c;
  endfunction

  task automatic run_random(input int idle, input int n);
    @(negedge clk);
    idle_pct = idle;
    for (int k = 0; k < n; k++) begin
      while (cmd_q.size() > 2) @(negedge clk);
      cmd_q.push_back(random_cmd());
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    write_fit(FIT_FIRST);
    @(negedge clk);

    // First fit from an empty heap.
    push_cmd(OP_ALLOC, 0, $urandom(), 0);       // smallest block, heap grows
    push_cmd(OP_ALLOC, 0, $urandom(), 0);
    push_cmd(OP_ALLOC, 100, $urandom(), 0);
    push_cmd(OP_FREE, $urandom(), 8, 0);
    push_cmd(OP_FREE, $urandom(), 8, 1);        // same block again, after a drain
    push_cmd(OP_FREE, $urandom(), 0, 0);        // unknown address
    push_cmd(OP_FREE, $urandom(), 65535, 0);    // unknown address, all ones
    push_cmd(OP_ALLOC, 65535, $urandom(), 0);   // widest request: no space
    push_cmd(OP_ALLOC, 65528, $urandom(), 0);   // needs the whole heap
    push_cmd(OP_FREE, $urandom(), 24, 0);
    push_cmd(OP_FREE, $urandom(), 16, 0);
    push_cmd(OP_ALLOC, 0, $urandom(), 0);       // reuses the first free block
    settle();

    // Best fit: exact fit, smallest surplus over the first candidate, ties.
    write_fit(FIT_BEST);
    @(negedge clk);
    push_cmd(OP_ALLOC, 100, $urandom(), 0);
    push_cmd(OP_ALLOC, 60, $urandom(), 0);
    push_cmd(OP_ALLOC, 0, $urandom(), 0);
    push_cmd(OP_ALLOC, 0, $urandom(), 0);
    push_cmd(OP_FREE, $urandom(), 24, 0);
    push_cmd(OP_FREE, $urandom(), 140, 0);
    push_cmd(OP_FREE, $urandom(), 16, 0);
    push_cmd(OP_FREE, $urandom(), 208, 0);
    push_cmd(OP_ALLOC, 50, $urandom(), 0);
    push_cmd(OP_ALLOC, 0, $urandom(), 0);
    push_cmd(OP_ALLOC, 0, $urandom(), 0);
    push_cmd(OP_ALLOC, 0, $urandom(), 0);

    // Random phases, alternating placement mode and sender pacing.
    run_random(0, 420);
    settle();
    write_fit(FIT_FIRST);
    run_random(78, 420);
    settle();
    write_fit(FIT_BEST);
    run_random(15, 420);
    settle();
    write_fit(FIT_FIRST);
    run_random(0, 420);
    settle();

    if (mismatches == 0 && reply_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
